// ----- rtl/pulse_width_bit_encoder_defines.svh -----
// assertion macros for the pulse width bit encoder checker
// no dependencies; taken in by the checker file only
`ifndef PULSE_WIDTH_BIT_ENCODER_DEFINES_SVH
`define PULSE_WIDTH_BIT_ENCODER_DEFINES_SVH

// property checked on every rising edge outside reset
`define PWBE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pwbe assertion failed");

// antecedent in one cycle implies consequent in the next
`define PWBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwbe assertion failed");

`endif

// ----- rtl/pwbe_pkg.sv -----
// shared types and constants of the pulse width bit encoder
// no dependencies
package pwbe_pkg;

  localparam int unsigned TickFieldW = 16;
  localparam int unsigned TickWidthDefault = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned StartResetTicks = 300;
  localparam int unsigned LongResetTicks = 100;
  localparam int unsigned ShortResetTicks = 40;
  localparam int unsigned StopResetTicks = 2200;

  typedef enum logic [CfgIndexW-1:0] {
    RegStart = 2'd0,
    RegLong  = 2'd1,
    RegShort = 2'd2,
    RegStop  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KindStart  = 2'd0,
    KindData   = 2'd1,
    KindParity = 2'd2,
    KindStop   = 2'd3
  } phase_kind_e;

  // phase numbering inside one byte's run
  localparam logic [4:0] PhStart     = 5'd0;
  localparam logic [4:0] PhFirstData = 5'd1;
  localparam logic [4:0] PhParityLo  = 5'd17;
  localparam logic [4:0] PhParityHi  = 5'd18;
  localparam logic [4:0] PhStop      = 5'd19;

  // one classified byte waiting for the back end
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             parity;
    logic             need_start;
    logic             last;
  } cmd_t;

endpackage

// ----- rtl/pwbe_queue.sv -----
// short command queue between front and back end
// depends on pwbe_pkg
module pwbe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pwbe_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output pwbe_pkg::cmd_t head_cmd_o
);

  localparam int unsigned PtrW = $clog2(pwbe_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(pwbe_pkg::QueueDepth + 1);

  pwbe_pkg::cmd_t entry_q [pwbe_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(pwbe_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(pwbe_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(pwbe_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/pwbe_front.sv -----
// front end: accepts bytes, works out parity and frame start, feeds the queue
// depends on pwbe_pkg
module pwbe_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pwbe_pkg::DataW-1:0] data_byte_i,
  input  logic                       last_byte_i,
  input  logic                       queue_full_i,
  output logic                       push_o,
  output pwbe_pkg::cmd_t             push_cmd_o
);

  logic frame_open_q, frame_open_d;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    push_cmd_o.data       = data_byte_i;
    push_cmd_o.parity     = ^data_byte_i;
    push_cmd_o.need_start = !frame_open_q;
    push_cmd_o.last       = last_byte_i;
  end

  // a frame stays open until a byte marked last goes through
  assign frame_open_d = push_o ? !last_byte_i : frame_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

// ----- rtl/pwbe_back.sv -----
// back end: timing registers and the phase sequencer with its output register
// depends on pwbe_pkg
module pwbe_back #(
  parameter int unsigned TICK_WIDTH = pwbe_pkg::TickWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [pwbe_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [pwbe_pkg::TickFieldW-1:0] cfg_wdata_i,
  input  logic                            head_valid_i,
  input  pwbe_pkg::cmd_t                  head_cmd_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pwbe_pkg::TickFieldW-1:0] duration_o,
  output logic [1:0]                      phase_kind_o,
  output logic                            last_of_run_o
);

  localparam int unsigned TwEff =
      (TICK_WIDTH < pwbe_pkg::TickFieldW) ? TICK_WIDTH : pwbe_pkg::TickFieldW;

  logic [TwEff-1:0] start_ticks_q, long_ticks_q, short_ticks_q, stop_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ticks_q <= TwEff'(pwbe_pkg::StartResetTicks);
      long_ticks_q  <= TwEff'(pwbe_pkg::LongResetTicks);
      short_ticks_q <= TwEff'(pwbe_pkg::ShortResetTicks);
      stop_ticks_q  <= TwEff'(pwbe_pkg::StopResetTicks);
    end else if (cfg_valid_i) begin
      case (pwbe_pkg::cfg_reg_e'(cfg_index_i))
        pwbe_pkg::RegStart: start_ticks_q <= cfg_wdata_i[TwEff-1:0];
        pwbe_pkg::RegLong:  long_ticks_q  <= cfg_wdata_i[TwEff-1:0];
        pwbe_pkg::RegShort: short_ticks_q <= cfg_wdata_i[TwEff-1:0];
        pwbe_pkg::RegStop:  stop_ticks_q  <= cfg_wdata_i[TwEff-1:0];
        default: ;
      endcase
    end
  end

  logic       started_q, started_d;
  logic [4:0] ph_q, ph_d;
  logic [4:0] ph_cur, half_idx;
  logic       cur_bit, is_long, is_final, load;
  logic [TwEff-1:0]        dur_sel;
  pwbe_pkg::phase_kind_e   kind_sel;

  logic                            out_valid_q, out_valid_d;
  logic [pwbe_pkg::TickFieldW-1:0] dur_q;
  logic [1:0]                      kind_q;
  logic                            lor_q;

  // a fresh head begins at the start phase only when it opens a frame
  assign ph_cur   = started_q ? ph_q
                  : (head_cmd_i.need_start ? pwbe_pkg::PhStart : pwbe_pkg::PhFirstData);
  assign half_idx = ph_cur - 5'd1;
  assign is_final = head_cmd_i.last ? (ph_cur == pwbe_pkg::PhStop)
                                    : (ph_cur == pwbe_pkg::PhParityHi);

  always_comb begin
    cur_bit = (ph_cur >= pwbe_pkg::PhParityLo) ? head_cmd_i.parity
                                               : head_cmd_i.data[half_idx[3:1]];
    // a one goes long then short, a zero short then long
    is_long = cur_bit ^ half_idx[0];
    if (ph_cur == pwbe_pkg::PhStart) begin
      kind_sel = pwbe_pkg::KindStart;
      dur_sel  = start_ticks_q;
    end else if (ph_cur == pwbe_pkg::PhStop) begin
      kind_sel = pwbe_pkg::KindStop;
      dur_sel  = stop_ticks_q;
    end else begin
      kind_sel = (ph_cur >= pwbe_pkg::PhParityLo) ? pwbe_pkg::KindParity
                                                  : pwbe_pkg::KindData;
      dur_sel  = is_long ? long_ticks_q : short_ticks_q;
    end
  end

  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && is_final;

  always_comb begin
    started_d   = started_q;
    ph_d        = ph_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      started_d   = !is_final;
      ph_d        = ph_cur + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dur_q  <= pwbe_pkg::TickFieldW'(dur_sel);
      kind_q <= kind_sel;
      lor_q  <= is_final;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duration_o    = dur_q;
  assign phase_kind_o  = kind_q;
  assign last_of_run_o = lor_q;

endmodule

// ----- rtl/pulse_width_bit_encoder.sv -----
// pulse width bit encoder: a byte passes a queue entry and then the output register
// before it shows on the output; one phase per cycle while out_ready_i is high, set by
// the back-end phase sequencer; the front takes a new byte while a queue slot is free
// reset clears queue, sequencer and output register, closes the frame and
// reloads timing registers with 300/100/40/2200 ticks; config port is always ready
module pulse_width_bit_encoder #(
  parameter int unsigned TICK_WIDTH = pwbe_pkg::TickWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pwbe_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [pwbe_pkg::TickFieldW-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pwbe_pkg::DataW-1:0]      data_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pwbe_pkg::TickFieldW-1:0] duration_o,
  output logic [1:0]                      phase_kind_o,
  output logic                            last_of_run_o
);

  logic           push, full, pop, head_valid;
  pwbe_pkg::cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  pwbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  pwbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  pwbe_back #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_valid_i  (head_valid),
    .head_cmd_i    (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .duration_o    (duration_o),
    .phase_kind_o  (phase_kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- rtl/pwbe_checker.sv -----
// port-level checker for the pulse width bit encoder, bound to the top level
// depends on pwbe_pkg and pulse_width_bit_encoder_defines.svh
`include "pulse_width_bit_encoder_defines.svh"

module pwbe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [pwbe_pkg::TickFieldW-1:0] duration_o,
  input logic [1:0]                      phase_kind_o,
  input logic                            last_of_run_o
);

  logic xfer;
  assign xfer = out_valid_o && out_ready_i;

  // stalled result holds its payload
  `PWBE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(duration_o) && $stable(phase_kind_o) && $stable(last_of_run_o))

  // the stop phase always closes a byte's run
  `PWBE_ASSERT(a_stop_is_last, clk_i, rst_ni, (xfer && phase_kind_o == pwbe_pkg::KindStop) |-> last_of_run_o)

  // after a stop, the next transfer opens a new frame
  `PWBE_ASSERT(a_start_after_stop, clk_i, rst_ni, (xfer && phase_kind_o == pwbe_pkg::KindStop) ##1 xfer |-> phase_kind_o == pwbe_pkg::KindStart)

  // a byte ending without stop keeps the frame open, so no start follows
  `PWBE_ASSERT(a_no_start_in_frame, clk_i, rst_ni, (xfer && last_of_run_o && phase_kind_o == pwbe_pkg::KindParity) ##1 xfer |-> phase_kind_o == pwbe_pkg::KindData)

endmodule

bind pulse_width_bit_encoder pwbe_checker u_pwbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .duration_o    (duration_o),
  .phase_kind_o  (phase_kind_o),
  .last_of_run_o (last_of_run_o)
);
